[rtl/svp_pkg.sv]
// svp_pkg: shared types and constants for the semantic version compare unit.
// No dependencies.
package svp_pkg;

	localparam int POS_W = 8;

	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic signed [1:0] ORD_LT = 2'sb11;
	localparam logic signed [1:0] ORD_EQ = 2'sb00;
	localparam logic signed [1:0] ORD_GT = 2'sb01;

	typedef enum logic [1:0] {
		PS_NUM,
		PS_PRE,
		PS_BUILD
	} parse_state_t;

	typedef enum logic [2:0] {
		SQ_LOAD,
		SQ_NUM,
		SQ_PRE,
		SQ_RD,
		SQ_EV,
		SQ_IDC,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic              ok;
		logic [2:0][31:0]  num;
		logic              has_pre;
		logic [POS_W-1:0]  pre_start;
		logic [POS_W-1:0]  pre_end;
	} parse_res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || (c == CH_DASH);
	endfunction

endpackage

[rtl/svp_parse.sv]
// svp_parse: streaming syntax checker for one version string, one byte a cycle.
// Builds major/minor/patch values and pre-release bounds. Depends on svp_pkg.
module svp_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        push,
	input  logic [7:0]                  ch,
	input  logic [svp_pkg::POS_W-1:0]   pos,
	output svp_pkg::parse_res_t         res
);

	svp_pkg::parse_state_t st_q;
	logic [1:0]  k_q;
	logic [1:0]  ndig_q;
	logic        lead0_q;
	logic [2:0][31:0] num_q;
	logic        err_q;
	logic [1:0]  idlen_q;
	logic        idnum_q;
	logic        idlead0_q;
	logic        has_pre_q;
	logic [svp_pkg::POS_W-1:0] pre_start_q;
	logic [svp_pkg::POS_W-1:0] pre_end_q;

	logic        dig;
	logic        idc;
	logic [35:0] mac;
	logic        id_ok_pre;
	logic        end_ok;

	assign dig = svp_pkg::is_digit(ch);
	assign idc = svp_pkg::is_ident(ch);
	// acc*10 + d as two shifts and two adds; overflow shows in the top nibble
	assign mac = ({4'b0, num_q[k_q]} << 3) + ({4'b0, num_q[k_q]} << 1) +
		{32'b0, ch[3:0]};
	assign id_ok_pre = (idlen_q != 2'd0) && !(idnum_q && idlen_q == 2'd2 && idlead0_q);

	always_comb begin
		unique case (st_q)
			svp_pkg::PS_NUM:   end_ok = (k_q == 2'd2) && (ndig_q != 2'd0);
			svp_pkg::PS_PRE:   end_ok = id_ok_pre;
			svp_pkg::PS_BUILD: end_ok = (idlen_q != 2'd0);
			default:           end_ok = 1'b0;
		endcase
	end

	assign res.ok        = !err_q && end_ok;
	assign res.num       = num_q;
	assign res.has_pre   = has_pre_q;
	assign res.pre_start = pre_start_q;
	assign res.pre_end   = (st_q == svp_pkg::PS_PRE) ? pos : pre_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= svp_pkg::PS_NUM;
			k_q         <= 2'd0;
			ndig_q      <= 2'd0;
			lead0_q     <= 1'b0;
			num_q       <= '0;
			err_q       <= 1'b0;
			idlen_q     <= 2'd0;
			idnum_q     <= 1'b1;
			idlead0_q   <= 1'b0;
			has_pre_q   <= 1'b0;
			pre_start_q <= '0;
			pre_end_q   <= '0;
		end else if (clear) begin
			st_q        <= svp_pkg::PS_NUM;
			k_q         <= 2'd0;
			ndig_q      <= 2'd0;
			lead0_q     <= 1'b0;
			num_q       <= '0;
			err_q       <= 1'b0;
			idlen_q     <= 2'd0;
			idnum_q     <= 1'b1;
			idlead0_q   <= 1'b0;
			has_pre_q   <= 1'b0;
			pre_start_q <= '0;
			pre_end_q   <= '0;
		end else if (push && !err_q) begin
			unique case (st_q)
				svp_pkg::PS_NUM: begin
					if (dig) begin
						if ((ndig_q == 2'd1 && lead0_q) || mac[35:32] != 4'd0) begin
							err_q <= 1'b1;
						end
						num_q[k_q] <= mac[31:0];
						if (ndig_q == 2'd0) begin
							lead0_q <= (ch == svp_pkg::CH_ZERO);
						end
						if (ndig_q != 2'd2) begin
							ndig_q <= ndig_q + 2'd1;
						end
					end else if (ch == svp_pkg::CH_DOT && ndig_q != 2'd0 && k_q != 2'd2) begin
						k_q    <= k_q + 2'd1;
						ndig_q <= 2'd0;
					end else if (ch == svp_pkg::CH_DASH && k_q == 2'd2 && ndig_q != 2'd0) begin
						st_q        <= svp_pkg::PS_PRE;
						has_pre_q   <= 1'b1;
						pre_start_q <= pos + 1'b1;
						idlen_q     <= 2'd0;
						idnum_q     <= 1'b1;
					end else if (ch == svp_pkg::CH_PLUS && k_q == 2'd2 && ndig_q != 2'd0) begin
						st_q    <= svp_pkg::PS_BUILD;
						idlen_q <= 2'd0;
						idnum_q <= 1'b1;
					end else begin
						err_q <= 1'b1;
					end
				end
				svp_pkg::PS_PRE, svp_pkg::PS_BUILD: begin
					if (ch == svp_pkg::CH_DOT) begin
						if ((st_q == svp_pkg::PS_PRE) ? !id_ok_pre : (idlen_q == 2'd0)) begin
							err_q <= 1'b1;
						end
						idlen_q <= 2'd0;
						idnum_q <= 1'b1;
					end else if (ch == svp_pkg::CH_PLUS && st_q == svp_pkg::PS_PRE) begin
						if (!id_ok_pre) begin
							err_q <= 1'b1;
						end
						pre_end_q <= pos;
						st_q      <= svp_pkg::PS_BUILD;
						idlen_q   <= 2'd0;
						idnum_q   <= 1'b1;
					end else if (idc) begin
						if (idlen_q == 2'd0) begin
							idlead0_q <= (ch == svp_pkg::CH_ZERO);
						end
						idnum_q <= idnum_q & dig;
						if (idlen_q != 2'd2) begin
							idlen_q <= idlen_q + 2'd1;
						end
					end else begin
						err_q <= 1'b1;
					end
				end
				default: err_q <= 1'b1;
			endcase
		end
	end

endmodule

[rtl/semver_precedence_compare_unit.sv]
// semver_precedence_compare_unit: top level, string stores and compare sequencer.
// Depends on svp_pkg and svp_parse.
//
//  channel   ports                         transfer when
//  -------   ---------------------------   ---------------------
//  input     start, busy, character,       start & !busy
//            terminator
//  result    done, status, order           done (one cycle, no stall)
//
// Bytes load one per cycle while busy is low; syntax is checked on the fly as bytes arrive.
// A right terminator starts the compare: major/minor/patch in turn, up to the
// first difference, through one shared 32-bit comparator; a pre-release setup
// step; then, if both have a pre-release, per identifier pair a registered
// memory read and an evaluate for each byte of the longer identifier plus one
// more such pair for its end, and a decide step; then the result cycle.
// An invalid pair goes straight to the result cycle. busy is high for that span.
// Reset clears the sequencer and load control state only; the byte stores need no clearing.
// The receiver cannot stall: the result is shown for exactly one cycle.
module semver_precedence_compare_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        character,
	input  logic              terminator,
	output logic              done,
	output logic              status,
	output logic signed [1:0] order
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int PW = svp_pkg::POS_W;

	logic [7:0] lmem [MAX_LEN];
	logic [7:0] rmem [MAX_LEN];
	logic [7:0] lrd_q, rrd_q;

	svp_pkg::seq_state_t sq_q, sq_nx;

	logic          loading_right_q;
	logic [PW-1:0] cnt_q;
	logic          ovf_q;
	logic          left_ovf_q;
	svp_pkg::parse_res_t lres_q, rres_q, pres;

	logic [1:0]    k_q;
	logic [PW-1:0] lo_q, ro_q;
	logic          ldone_q, rdone_q, lnum_q, rnum_q;
	logic signed [1:0] lenrel_q, diff_q;
	logic          status_q;
	logic signed [1:0] order_q;

	logic accept, push, lterm, rterm, left_ok, right_ok;
	logic lact, ract, lend, rend, lstep, rstep;
	logic signed [1:0] idc;
	logic [PW-1:0] lo2, ro2;
	logic more;

	assign accept = start && !busy;
	assign push   = accept && !terminator && (cnt_q < PW'(MAX_LEN));
	assign lterm  = accept && terminator && !loading_right_q;
	assign rterm  = accept && terminator && loading_right_q;
	assign left_ok  = !left_ovf_q && lres_q.ok;
	assign right_ok = !ovf_q && pres.ok;

	svp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (lterm || rterm),
		.push   (push),
		.ch     (character),
		.pos    (cnt_q),
		.res    (pres)
	);

	// byte stores
	always_ff @(posedge clk) begin
		if (push && !loading_right_q) begin
			lmem[cnt_q[AW-1:0]] <= character;
		end
		if (push && loading_right_q) begin
			rmem[cnt_q[AW-1:0]] <= character;
		end
		lrd_q <= lmem[lo_q[AW-1:0]];
		rrd_q <= rmem[ro_q[AW-1:0]];
	end

	// pre-release walk, one byte of each unfinished side per evaluate cycle
	assign lact  = !ldone_q;
	assign ract  = !rdone_q;
	assign lend  = lact && ((lo_q == lres_q.pre_end) || (lrd_q == svp_pkg::CH_DOT));
	assign rend  = ract && ((ro_q == rres_q.pre_end) || (rrd_q == svp_pkg::CH_DOT));
	assign lstep = lact && !lend;
	assign rstep = ract && !rend;

	always_comb begin
		if (lnum_q != rnum_q) begin
			idc = lnum_q ? svp_pkg::ORD_LT : svp_pkg::ORD_GT;
		end else if (lnum_q && lenrel_q != svp_pkg::ORD_EQ) begin
			idc = lenrel_q;
		end else if (diff_q != svp_pkg::ORD_EQ) begin
			idc = diff_q;
		end else begin
			idc = lenrel_q;
		end
	end

	assign lo2  = (lo_q < lres_q.pre_end) ? lo_q + 1'b1 : lo_q;
	assign ro2  = (ro_q < rres_q.pre_end) ? ro_q + 1'b1 : ro_q;
	assign more = (lo2 < lres_q.pre_end) && (ro2 < rres_q.pre_end);

	// next state
	always_comb begin
		sq_nx = sq_q;
		unique case (sq_q)
			svp_pkg::SQ_LOAD: begin
				if (rterm) begin
					sq_nx = (left_ok && right_ok) ? svp_pkg::SQ_NUM : svp_pkg::SQ_DONE;
				end
			end
			svp_pkg::SQ_NUM: begin
				if (lres_q.num[k_q] != rres_q.num[k_q]) begin
					sq_nx = svp_pkg::SQ_DONE;
				end else if (k_q == 2'd2) begin
					sq_nx = svp_pkg::SQ_PRE;
				end
			end
			svp_pkg::SQ_PRE: begin
				sq_nx = (lres_q.has_pre && rres_q.has_pre) ? svp_pkg::SQ_RD : svp_pkg::SQ_DONE;
			end
			svp_pkg::SQ_RD: sq_nx = svp_pkg::SQ_EV;
			svp_pkg::SQ_EV: begin
				sq_nx = ((ldone_q || lend) && (rdone_q || rend)) ? svp_pkg::SQ_IDC
					: svp_pkg::SQ_RD;
			end
			svp_pkg::SQ_IDC: begin
				sq_nx = (idc == svp_pkg::ORD_EQ && more) ? svp_pkg::SQ_RD : svp_pkg::SQ_DONE;
			end
			svp_pkg::SQ_DONE: sq_nx = svp_pkg::SQ_LOAD;
			default:          sq_nx = svp_pkg::SQ_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		busy   = (sq_q != svp_pkg::SQ_LOAD);
		done   = (sq_q == svp_pkg::SQ_DONE);
		status = status_q;
		order  = order_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q            <= svp_pkg::SQ_LOAD;
			loading_right_q <= 1'b0;
			cnt_q           <= '0;
			ovf_q           <= 1'b0;
			left_ovf_q      <= 1'b0;
		end else begin
			sq_q <= sq_nx;
			if (accept && !terminator) begin
				if (cnt_q < PW'(MAX_LEN)) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (lterm) begin
				left_ovf_q      <= ovf_q;
				loading_right_q <= 1'b1;
				cnt_q           <= '0;
				ovf_q           <= 1'b0;
			end
			if (rterm) begin
				loading_right_q <= 1'b0;
				cnt_q           <= '0;
				ovf_q           <= 1'b0;
			end
		end
	end

	// compare datapath
	always_ff @(posedge clk) begin
		if (lterm) begin
			lres_q <= pres;
		end
		unique case (sq_q)
			svp_pkg::SQ_LOAD: begin
				if (rterm) begin
					rres_q   <= pres;
					k_q      <= 2'd0;
					status_q <= !(left_ok && right_ok);
					order_q  <= svp_pkg::ORD_EQ;
				end
			end
			svp_pkg::SQ_NUM: begin
				if (lres_q.num[k_q] != rres_q.num[k_q]) begin
					order_q <= (lres_q.num[k_q] < rres_q.num[k_q]) ? svp_pkg::ORD_LT
						: svp_pkg::ORD_GT;
				end
				k_q <= k_q + 2'd1;
			end
			svp_pkg::SQ_PRE: begin
				if (lres_q.has_pre != rres_q.has_pre) begin
					order_q <= lres_q.has_pre ? svp_pkg::ORD_LT : svp_pkg::ORD_GT;
				end
				lo_q     <= lres_q.pre_start;
				ro_q     <= rres_q.pre_start;
				ldone_q  <= 1'b0;
				rdone_q  <= 1'b0;
				lnum_q   <= 1'b1;
				rnum_q   <= 1'b1;
				lenrel_q <= svp_pkg::ORD_EQ;
				diff_q   <= svp_pkg::ORD_EQ;
			end
			svp_pkg::SQ_EV: begin
				if (lstep) begin
					lnum_q <= lnum_q & svp_pkg::is_digit(lrd_q);
					lo_q   <= lo_q + 1'b1;
				end
				if (rstep) begin
					rnum_q <= rnum_q & svp_pkg::is_digit(rrd_q);
					ro_q   <= ro_q + 1'b1;
				end
				if (lstep && rstep && diff_q == svp_pkg::ORD_EQ && lrd_q != rrd_q) begin
					diff_q <= (lrd_q < rrd_q) ? svp_pkg::ORD_LT : svp_pkg::ORD_GT;
				end
				if (lend && rstep) begin
					lenrel_q <= svp_pkg::ORD_LT;
				end
				if (rend && lstep) begin
					lenrel_q <= svp_pkg::ORD_GT;
				end
				ldone_q <= ldone_q | lend;
				rdone_q <= rdone_q | rend;
			end
			svp_pkg::SQ_IDC: begin
				lo_q     <= lo2;
				ro_q     <= ro2;
				ldone_q  <= 1'b0;
				rdone_q  <= 1'b0;
				lnum_q   <= 1'b1;
				rnum_q   <= 1'b1;
				lenrel_q <= svp_pkg::ORD_EQ;
				diff_q   <= svp_pkg::ORD_EQ;
				if (idc != svp_pkg::ORD_EQ) begin
					order_q <= idc;
				end else if (!more) begin
					order_q <= (lo2 < lres_q.pre_end) ? svp_pkg::ORD_GT
						: ((ro2 < rres_q.pre_end) ? svp_pkg::ORD_LT : svp_pkg::ORD_EQ);
				end
			end
			default: begin
			end
		endcase
	end

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
	a_bad_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (order == svp_pkg::ORD_EQ)) else $error("order on invalid");
	a_rterm_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rterm |=> busy) else $error("no compare after right terminator");
	a_ev_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_q == svp_pkg::SQ_EV) |-> ($past(sq_q) == svp_pkg::SQ_RD))
		else $error("evaluate without read");

endmodule
